// File: rtl/locd_pkg.sv
// ----------------------------------------------------------------------------
// Lock order detector package
// Shared widths, codes and control bundles of the lock order cycle detector.
// ----------------------------------------------------------------------------
package locd_pkg;

    localparam int LOCK_W         = 6;
    localparam int STATUS_W       = 3;
    localparam int COUNT_W        = 5;
    localparam int DEF_MAX_LOCKS  = 64;
    localparam int DEF_HELD_DEPTH = 16;

    localparam logic REQ_ACQUIRE = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 3'd0,
        STATUS_DEADLOCK  = 3'd1,
        STATUS_POP_EMPTY = 3'd2,
        STATUS_MISMATCH  = 3'd3,
        STATUS_OVERFLOW  = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TOP,
        ST_EDGE,
        ST_PICK,
        ST_EXPAND,
        ST_DONE
    } ctrl_state_t;

    // Commands to the held lock stack.
    typedef struct packed {
        logic rd;
        logic push;
        logic pop;
    } held_cmd_t;

    // Commands to the graph search unit.
    typedef struct packed {
        logic init;
        logic pick;
        logic expand;
    } search_ctl_t;

endpackage

// File: rtl/lock_order_cycle_detector_core.sv
// ----------------------------------------------------------------------------
// Lock order cycle detector
// Tracks held locks and the observed lock order graph, and reports an
// acquire that would close a cycle in that graph.
// ----------------------------------------------------------------------------
// Usage:
// A request word (req_type, lock_id) is taken when req_valid is high and
// req_stall is low. One response word (status, new_edge, held_count) follows
// for every request on the rsp channel, taken when rsp_valid is high and
// rsp_stall is low. The block works on one request at a time.
// A release, or an acquire that needs no graph check, goes from ST_TOP
// straight to ST_DONE, where its response is registered. An acquire whose
// order edge is already stored first checks the top lock's row in ST_EDGE.
// An acquire that adds an edge runs a graph search that reads one adjacency
// row per reachable lock expanded, up to MAX_LOCKS, via ST_PICK and ST_EXPAND.
// While a response waits under rsp_stall the next request is still taken
// and processed; its response waits until the output register frees.
// Reset empties the held stack and the order graph at once, with no clearing
// pass; requests are taken from the first cycle after reset.
// ----------------------------------------------------------------------------
module lock_order_cycle_detector_core
    import locd_pkg::*;
#(
    parameter int MAX_LOCKS  = DEF_MAX_LOCKS,
    parameter int HELD_DEPTH = DEF_HELD_DEPTH
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  logic                req_type,
    input  logic [LOCK_W-1:0]   lock_id,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output logic [STATUS_W-1:0] status,
    output logic                new_edge,
    output logic [COUNT_W-1:0]  held_count
);

    localparam int NODE_W  = $clog2(MAX_LOCKS);
    localparam int PTR_W   = $clog2(HELD_DEPTH + 1);
    localparam int RANGE_W = ($clog2(MAX_LOCKS + 1) > LOCK_W) ? $clog2(MAX_LOCKS + 1) : LOCK_W;
    localparam logic [MAX_LOCKS-1:0] ONE = MAX_LOCKS'(1);

    ctrl_state_t          state_reg;
    ctrl_state_t          state_next;
    logic                 req_reg;
    logic [LOCK_W-1:0]    id_reg;
    status_t              status_reg;
    status_t              status_next;
    logic                 edge_reg;
    logic                 edge_next;
    logic [MAX_LOCKS-1:0] edge_row_reg;

    logic                 rsp_valid_reg;
    status_t              rsp_status_reg;
    logic                 rsp_edge_reg;
    logic [COUNT_W-1:0]   rsp_count_reg;

    logic                 req_accept;
    logic                 rsp_load;
    logic                 need_search;
    logic                 id_in_range;
    logic                 top_in_range;

    held_cmd_t            held_cmd;
    logic [LOCK_W-1:0]    held_top;
    logic [PTR_W-1:0]     held_ptr;

    logic                 graph_rd_en;
    logic [NODE_W-1:0]    graph_rd_addr;
    logic [MAX_LOCKS-1:0] graph_row;
    logic                 graph_wr_en;
    logic [MAX_LOCKS-1:0] graph_wr_row;

    search_ctl_t          search_ctl;
    logic [NODE_W-1:0]    pick_node;
    logic                 pending_empty;
    logic                 found;

    logic [NODE_W-1:0]    id_node;
    logic [NODE_W-1:0]    top_node;

    assign req_stall  = (state_reg != ST_IDLE);
    assign req_accept = req_valid && !req_stall;
    assign rsp_load   = (state_reg == ST_DONE) && (!rsp_valid_reg || !rsp_stall);

    assign id_node      = NODE_W'(id_reg);
    assign top_node     = NODE_W'(held_top);
    assign id_in_range  = RANGE_W'(id_reg) < RANGE_W'(MAX_LOCKS);
    assign top_in_range = RANGE_W'(held_top) < RANGE_W'(MAX_LOCKS);
    // An acquire under a different, known top lock may add an order edge.
    assign need_search  = (held_ptr != '0) && (held_top != id_reg) &&
                          id_in_range && top_in_range;

    assign graph_wr_row = edge_row_reg | (ONE << id_node);

    locd_held_stack #(
        .HELD_DEPTH (HELD_DEPTH),
        .PTR_W      (PTR_W)
    ) u_held (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (held_cmd),
        .push_id (id_reg),
        .top_id  (held_top),
        .ptr     (held_ptr)
    );

    locd_order_graph #(
        .MAX_LOCKS (MAX_LOCKS),
        .NODE_W    (NODE_W)
    ) u_graph (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (graph_rd_en),
        .rd_addr (graph_rd_addr),
        .rd_row  (graph_row),
        .wr_en   (graph_wr_en),
        .wr_addr (top_node),
        .wr_row  (graph_wr_row)
    );

    locd_search #(
        .MAX_LOCKS (MAX_LOCKS),
        .NODE_W    (NODE_W)
    ) u_search (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (search_ctl),
        .start         (id_node),
        .target        (top_node),
        .row           (graph_row),
        .pick_node     (pick_node),
        .pending_empty (pending_empty),
        .found         (found)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_accept)
                begin
                    state_next = ST_TOP;
                end
            end
            ST_TOP:
            begin
                if (req_reg == REQ_ACQUIRE && held_ptr < PTR_W'(HELD_DEPTH) && need_search)
                begin
                    state_next = ST_EDGE;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_EDGE:
            begin
                state_next = graph_row[id_node] ? ST_DONE : ST_PICK;
            end
            ST_PICK:
            begin
                state_next = pending_empty ? ST_DONE : ST_EXPAND;
            end
            ST_EXPAND:
            begin
                state_next = found ? ST_DONE : ST_PICK;
            end
            ST_DONE:
            begin
                if (rsp_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        held_cmd      = '0;
        search_ctl    = '0;
        graph_rd_en   = 1'b0;
        graph_rd_addr = top_node;
        graph_wr_en   = 1'b0;
        status_next   = status_reg;
        edge_next     = edge_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                held_cmd.rd = req_accept;
                status_next = STATUS_OK;
                edge_next   = 1'b0;
            end
            ST_TOP:
            begin
                if (req_reg == REQ_RELEASE)
                begin
                    if (held_ptr == '0)
                    begin
                        status_next = STATUS_POP_EMPTY;
                    end
                    else if (held_top != id_reg)
                    begin
                        status_next = STATUS_MISMATCH;
                    end
                    else
                    begin
                        held_cmd.pop = 1'b1;
                    end
                end
                else if (held_ptr >= PTR_W'(HELD_DEPTH))
                begin
                    status_next = STATUS_OVERFLOW;
                end
                else if (need_search)
                begin
                    graph_rd_en = 1'b1;
                end
                else
                begin
                    held_cmd.push = 1'b1;
                end
            end
            ST_EDGE:
            begin
                if (graph_row[id_node])
                begin
                    held_cmd.push = 1'b1;
                end
                else
                begin
                    search_ctl.init = 1'b1;
                end
            end
            ST_PICK:
            begin
                if (pending_empty)
                begin
                    // No path back to the top lock: store the new edge.
                    graph_wr_en   = 1'b1;
                    held_cmd.push = 1'b1;
                    edge_next     = 1'b1;
                end
                else
                begin
                    graph_rd_en     = 1'b1;
                    graph_rd_addr   = pick_node;
                    search_ctl.pick = 1'b1;
                end
            end
            ST_EXPAND:
            begin
                search_ctl.expand = 1'b1;
                if (found)
                begin
                    status_next   = STATUS_DEADLOCK;
                    held_cmd.push = 1'b1;
                end
            end
            ST_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            status_reg    <= STATUS_OK;
            edge_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            status_reg <= status_next;
            edge_reg   <= edge_next;
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            req_reg <= req_type;
            id_reg  <= lock_id;
        end
        if (state_reg == ST_EDGE)
        begin
            edge_row_reg <= graph_row;
        end
        if (rsp_load)
        begin
            rsp_status_reg <= status_reg;
            rsp_edge_reg   <= edge_reg;
            rsp_count_reg  <= COUNT_W'(held_ptr);
        end
    end

    assign rsp_valid  = rsp_valid_reg;
    assign status     = rsp_status_reg;
    assign new_edge   = rsp_edge_reg;
    assign held_count = rsp_count_reg;

endmodule

// File: rtl/locd_held_stack.sv
// ----------------------------------------------------------------------------
// Held lock stack
// Synchronous memory of held lock ids with its stack pointer; the top entry
// is read into a register on a read command.
// ----------------------------------------------------------------------------
module locd_held_stack
    import locd_pkg::*;
#(
    parameter int HELD_DEPTH = DEF_HELD_DEPTH,
    parameter int PTR_W      = $clog2(HELD_DEPTH + 1)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  held_cmd_t         cmd,
    input  logic [LOCK_W-1:0] push_id,
    output logic [LOCK_W-1:0] top_id,
    output logic [PTR_W-1:0]  ptr
);

    localparam int ADDR_W = $clog2(HELD_DEPTH);

    logic [LOCK_W-1:0] mem [HELD_DEPTH];
    logic [LOCK_W-1:0] top_reg;
    logic [PTR_W-1:0]  ptr_reg;
    logic [PTR_W-1:0]  ptr_next;
    logic [PTR_W-1:0]  top_ptr;

    assign top_ptr = ptr_reg - PTR_W'(1);

    always_comb
    begin
        ptr_next = ptr_reg;
        if (cmd.push)
        begin
            ptr_next = ptr_reg + PTR_W'(1);
        end
        else if (cmd.pop)
        begin
            ptr_next = ptr_reg - PTR_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg <= '0;
        end
        else
        begin
            ptr_reg <= ptr_next;
        end
    end

    // The read of an empty stack returns junk; the caller ignores it then.
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            mem[ptr_reg[ADDR_W-1:0]] <= push_id;
        end
        if (cmd.rd)
        begin
            top_reg <= mem[top_ptr[ADDR_W-1:0]];
        end
    end

    assign top_id = top_reg;
    assign ptr    = ptr_reg;

endmodule

// File: rtl/locd_order_graph.sv
// ----------------------------------------------------------------------------
// Lock order graph
// Adjacency matrix in a synchronous memory, one row per lock, with a valid
// bit per row so that rows never written read as empty after reset.
// ----------------------------------------------------------------------------
module locd_order_graph
    import locd_pkg::*;
#(
    parameter int MAX_LOCKS = DEF_MAX_LOCKS,
    parameter int NODE_W    = $clog2(MAX_LOCKS)
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 rd_en,
    input  logic [NODE_W-1:0]    rd_addr,
    output logic [MAX_LOCKS-1:0] rd_row,
    input  logic                 wr_en,
    input  logic [NODE_W-1:0]    wr_addr,
    input  logic [MAX_LOCKS-1:0] wr_row
);

    logic [MAX_LOCKS-1:0] mem [MAX_LOCKS];
    logic [MAX_LOCKS-1:0] row_valid_reg;
    logic [MAX_LOCKS-1:0] rd_data_reg;
    logic                 rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_row;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                row_valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= row_valid_reg[rd_addr];
            end
        end
    end

    assign rd_row = rd_valid_reg ? rd_data_reg : '0;

endmodule

// File: rtl/locd_search.sv
// ----------------------------------------------------------------------------
// Graph search unit
// Keeps the visited set and the set of nodes still to expand, hands out the
// next node to expand and flags when an expanded row reaches the target.
// ----------------------------------------------------------------------------
module locd_search
    import locd_pkg::*;
#(
    parameter int MAX_LOCKS = DEF_MAX_LOCKS,
    parameter int NODE_W    = $clog2(MAX_LOCKS)
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  search_ctl_t          ctl,
    input  logic [NODE_W-1:0]    start,
    input  logic [NODE_W-1:0]    target,
    input  logic [MAX_LOCKS-1:0] row,
    output logic [NODE_W-1:0]    pick_node,
    output logic                 pending_empty,
    output logic                 found
);

    localparam logic [MAX_LOCKS-1:0] ONE = MAX_LOCKS'(1);

    logic [MAX_LOCKS-1:0] visited_reg;
    logic [MAX_LOCKS-1:0] pending_reg;
    logic [NODE_W-1:0]    target_reg;

    function automatic logic [NODE_W-1:0] first_set(input logic [MAX_LOCKS-1:0] v);
        logic [NODE_W-1:0] idx;
        idx = '0;
        for (int i = MAX_LOCKS - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                idx = NODE_W'(i);
            end
        end
        return idx;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            visited_reg <= '0;
            pending_reg <= '0;
        end
        else if (ctl.init)
        begin
            visited_reg <= ONE << start;
            pending_reg <= ONE << start;
        end
        else if (ctl.pick)
        begin
            pending_reg[pick_node] <= 1'b0;
        end
        else if (ctl.expand)
        begin
            visited_reg <= visited_reg | row;
            pending_reg <= pending_reg | (row & ~visited_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.init)
        begin
            target_reg <= target;
        end
    end

    assign pick_node     = first_set(pending_reg);
    assign pending_empty = (pending_reg == '0);
    // The search stops as soon as the target is seen, so it is never visited
    // before this point.
    assign found         = row[target_reg];

endmodule

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// Lock order cycle detector testbench
// Drives acquire and release words into the detector and tracks its own copy
// of the held stack and the order graph, so every response word can be
// checked field by field. A directed sequence covers the corner cases, then
// a full stack is pushed under long response backpressure, and then random
// nested lock traffic runs over small lock pools that change over time.
// ----------------------------------------------------------------------------
module tb;
    import locd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_LOCKS    = DEF_MAX_LOCKS;
    localparam int HELD_DEPTH   = DEF_HELD_DEPTH;
    localparam int RANDOM_WORDS = 1250;
    localparam int CYCLE_LIMIT  = 1_500_000;
    localparam int SETTLE_WAIT  = 200;

    typedef struct packed {
        status_t              status;
        logic                 new_edge;
        logic [COUNT_W-1:0]   held_count;
    } lock_verdict_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                req_valid = 1'b0;
    logic                req_stall;
    logic                req_type = REQ_ACQUIRE;
    logic [LOCK_W-1:0]   lock_id = '0;
    logic                rsp_valid;
    logic                rsp_stall = 1'b0;
    logic [STATUS_W-1:0] status;
    logic                new_edge;
    logic [COUNT_W-1:0]  held_count;

    // Mirror of the detector state.
    logic [MAX_LOCKS-1:0] lock_order [MAX_LOCKS];
    logic [LOCK_W-1:0]    held_locks [HELD_DEPTH];
    int                   held_depth = 0;

    lock_verdict_t pending_verdicts [$];
    lock_verdict_t oldest_verdict;

    int fail_count = 0;
    int cycle_count = 0;
    int words_sent = 0;
    int edges_added = 0;
    int status_hits [5] = '{default: 0};

    bit sender_on = 1'b0;
    int burst_left = 0;
    int long_hold_cycles = 0;
    int stall_mode = 0;
    int mode_left = 0;
    int stall_phase = 0;

    lock_order_cycle_detector_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req_type   (req_type),
        .lock_id    (lock_id),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .status     (status),
        .new_edge   (new_edge),
        .held_count (held_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timed out with %0d responses outstanding", $time,
                     pending_verdicts.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    // Depth first walk along stored order edges.
    function automatic bit path_exists(int src, int dst);
        logic [MAX_LOCKS-1:0] visited;
        int                   frontier [$];
        int                   node;
        visited = '0;
        visited[src] = 1'b1;
        frontier.push_back(src);
        while (frontier.size() > 0)
        begin
            node = frontier.pop_back();
            if (node == dst)
                return 1'b1;
            for (int n = 0; n < MAX_LOCKS; n++)
            begin
                if (lock_order[node][n] && !visited[n])
                begin
                    visited[n] = 1'b1;
                    frontier.push_back(n);
                end
            end
        end
        return 1'b0;
    endfunction

    // Applies one event to the mirrored state and returns the response word.
    // Lock ids are never out of range here, since LOCK_W bits cover MAX_LOCKS.
    function automatic lock_verdict_t track_lock_event(logic kind, logic [LOCK_W-1:0] id);
        lock_verdict_t     v;
        logic [LOCK_W-1:0] top;
        v.status = STATUS_OK;
        v.new_edge = 1'b0;
        if (kind == REQ_ACQUIRE)
        begin
            if (held_depth >= HELD_DEPTH)
                v.status = STATUS_OVERFLOW;
            else
            begin
                if (held_depth > 0)
                begin
                    top = held_locks[held_depth-1];
                    if (top != id && !lock_order[top][id])
                    begin
                        // The lock is still pushed when the edge would close a cycle.
                        if (path_exists(int'(id), int'(top)))
                            v.status = STATUS_DEADLOCK;
                        else
                        begin
                            lock_order[top][id] = 1'b1;
                            v.new_edge = 1'b1;
                        end
                    end
                end
                held_locks[held_depth] = id;
                held_depth++;
            end
        end
        else if (held_depth == 0)
            v.status = STATUS_POP_EMPTY;
        else if (held_locks[held_depth-1] != id)
            v.status = STATUS_MISMATCH;
        else
            held_depth--;
        v.held_count = held_depth[COUNT_W-1:0];
        return v;
    endfunction

    function automatic logic [LOCK_W-1:0] random_lock();
        return LOCK_W'($urandom_range(0, MAX_LOCKS - 1));
    endfunction

    task automatic pause_sender();
        if (sender_on)
        begin
            req_valid <= 1'b0;
            sender_on = 1'b0;
        end
    endtask

    // Offers one word, waits for it to be taken, then maybe idles a while.
    task automatic send_word(logic kind, logic [LOCK_W-1:0] id);
        lock_verdict_t v;
        int            gap;
        req_valid <= 1'b1;
        req_type  <= kind;
        lock_id   <= id;
        sender_on = 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        v = track_lock_event(kind, id);
        pending_verdicts.push_back(v);
        words_sent++;
        edges_added += int'(v.new_edge);
        status_hits[v.status]++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                pause_sender();
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic drain_responses();
        pause_sender();
        while (pending_verdicts.size() > 0)
            @(posedge clk);
    endtask

    task automatic unwind_held();
        while (held_depth > 0)
            send_word(REQ_RELEASE, held_locks[held_depth-1]);
    endtask

    // Receiver: a long hold when asked for one, otherwise a changing pattern.
    always @(posedge clk)
    begin
        if (long_hold_cycles > 0)
        begin
            rsp_stall <= 1'b1;
            long_hold_cycles--;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                mode_left = $urandom_range(50, 300);
            end
            mode_left--;
            stall_phase++;
            case (stall_mode)
                0:       rsp_stall <= 1'b0;
                1:       rsp_stall <= ($urandom_range(0, 9) < 3);
                2:       rsp_stall <= ($urandom_range(0, 9) < 7);
                default: rsp_stall <= ((stall_phase % 7) < 3);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_verdicts.size() == 0)
            begin
                fail_count++;
                $display("%0t: unexpected response word: expected none, actual %0d/%0d/%0d",
                         $time, status, new_edge, held_count);
            end
            else
            begin
                oldest_verdict = pending_verdicts.pop_front();
                if (status !== oldest_verdict.status)
                begin
                    fail_count++;
                    $display("%0t: status expected %0d actual %0d", $time,
                             oldest_verdict.status, status);
                end
                if (new_edge !== oldest_verdict.new_edge)
                begin
                    fail_count++;
                    $display("%0t: new_edge expected %0d actual %0d", $time,
                             oldest_verdict.new_edge, new_edge);
                end
                if (held_count !== oldest_verdict.held_count)
                begin
                    fail_count++;
                    $display("%0t: held_count expected %0d actual %0d", $time,
                             oldest_verdict.held_count, held_count);
                end
            end
        end
    end

    // Empty pop, mismatch, same lock as top, known edge, a direct cycle and
    // a cycle closed over several hops.
    task automatic test_directed_cases();
        send_word(REQ_RELEASE, 6'd0);
        send_word(REQ_ACQUIRE, 6'd63);
        send_word(REQ_RELEASE, 6'd0);
        send_word(REQ_ACQUIRE, 6'd0);
        send_word(REQ_ACQUIRE, 6'd0);
        send_word(REQ_RELEASE, 6'd0);
        send_word(REQ_RELEASE, 6'd0);
        send_word(REQ_RELEASE, 6'd63);
        send_word(REQ_ACQUIRE, 6'd0);
        send_word(REQ_ACQUIRE, 6'd63);
        send_word(REQ_RELEASE, 6'd63);
        send_word(REQ_RELEASE, 6'd0);
        send_word(REQ_ACQUIRE, 6'd63);
        send_word(REQ_ACQUIRE, 6'd0);
        send_word(REQ_ACQUIRE, 6'd21);
        send_word(REQ_ACQUIRE, 6'd42);
        send_word(REQ_ACQUIRE, 6'd63);
        unwind_held();
        drain_responses();
    endtask

    // Fills the held stack past its depth while responses are held back.
    task automatic test_full_stack_under_backpressure();
        unwind_held();
        drain_responses();
        long_hold_cycles = 400;
        repeat (HELD_DEPTH + 2) send_word(REQ_ACQUIRE, random_lock());
        unwind_held();
        drain_responses();
    endtask

    // Mostly nested acquire and release over a small pool of locks, with some
    // random words and broken releases mixed in.
    task automatic test_random_traffic();
        int                sent;
        int                phase_len;
        int                push_bias;
        int                roll;
        logic              kind;
        logic [LOCK_W-1:0] id;
        logic [LOCK_W-1:0] pool [$];
        sent = 0;
        while (sent < RANDOM_WORDS)
        begin
            pool.delete();
            repeat ($urandom_range(3, 12)) pool.push_back(random_lock());
            push_bias = $urandom_range(40, 70);
            phase_len = $urandom_range(60, 200);
            repeat (phase_len)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 6)
                begin
                    kind = 1'($urandom_range(0, 1));
                    id = random_lock();
                end
                else if (roll < 10)
                begin
                    kind = REQ_RELEASE;
                    id = pool[$urandom_range(0, pool.size() - 1)];
                end
                else if (held_depth == 0 || (held_depth < HELD_DEPTH && roll < push_bias)
                         || (held_depth >= HELD_DEPTH && roll < 15))
                begin
                    kind = REQ_ACQUIRE;
                    id = pool[$urandom_range(0, pool.size() - 1)];
                end
                else
                begin
                    kind = REQ_RELEASE;
                    id = held_locks[held_depth-1];
                end
                send_word(kind, id);
                sent++;
            end
            if ($urandom_range(0, 3) == 0)
                drain_responses();
        end
    endtask

    initial
    begin
        foreach (lock_order[i])
            lock_order[i] = '0;
        foreach (held_locks[i])
            held_locks[i] = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_full_stack_under_backpressure();
        test_random_traffic();
        drain_responses();
        repeat (SETTLE_WAIT) @(posedge clk);
        $display("Ran %0d words: %0d new order edges, %0d deadlocks, %0d overflows,",
                 words_sent, edges_added, status_hits[STATUS_DEADLOCK],
                 status_hits[STATUS_OVERFLOW]);
        $display("%0d empty pops, %0d mismatched pops and %0d field mismatches.",
                 status_hits[STATUS_POP_EMPTY], status_hits[STATUS_MISMATCH], fail_count);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
